>>> sv/occ_pkg.sv
// Shared types, codes and constants for the occupancy grid segment checker.
package occ_pkg;

	localparam int GRID_W_DEF    = 256;
	localparam int GRID_H_DEF    = 256;
	localparam int MAX_STEPS_DEF = 512;

	localparam int STORE_AW   = 16;
	localparam int QDEPTH     = 2;
	localparam int DIV_BITS   = 34;
	localparam int ROOT_ITERS = 33;

	localparam logic [1:0] FN_WRITE = 2'd0;
	localparam logic [1:0] FN_POINT = 2'd1;
	localparam logic [1:0] FN_SEG   = 2'd2;

	localparam logic [2:0] REG_MIN_X   = 3'd0;
	localparam logic [2:0] REG_MIN_Y   = 3'd1;
	localparam logic [2:0] REG_MAX_X   = 3'd2;
	localparam logic [2:0] REG_MAX_Y   = 3'd3;
	localparam logic [2:0] REG_SCALE_X = 3'd4;
	localparam logic [2:0] REG_SCALE_Y = 3'd5;
	localparam logic [2:0] REG_STEP    = 3'd6;

	localparam logic [1:0] ST_FREE = 2'd0;
	localparam logic [1:0] ST_HIT  = 2'd1;
	localparam logic [1:0] ST_OUT  = 2'd2;

	localparam logic [8:0] PV_OFF_GRID = 9'h1FF;

	typedef struct packed {
		logic [1:0]          func;
		logic signed [31:0]  start_x;
		logic signed [31:0]  start_y;
		logic signed [31:0]  end_x;
		logic signed [31:0]  end_y;
		logic [15:0]         cell_addr;
		logic [7:0]          cell_value;
		logic                oob;
	} item_t;

	typedef struct packed {
		logic signed [31:0] min_x;
		logic signed [31:0] min_y;
		logic signed [31:0] max_x;
		logic signed [31:0] max_y;
		logic [31:0]        scale_x;
		logic [31:0]        scale_y;
		logic [31:0]        step_len;
	} cfg_t;

	typedef enum logic [3:0] {
		B_IDLE, B_SQX, B_SQY, B_SUM, B_ROOT, B_DIVN, B_NSET, B_DIVX, B_LOADY,
		B_DIVY, B_WALK0, B_SAMP, B_MULX, B_MULY, B_ADDR, B_CHK
	} bstate_t;

	typedef enum logic {B_RUN, B_DONE} bdone_t;

endpackage

>>> sv/occ_front.sv
// Front end: accepts requests, tests segment endpoints against the box, drops unused codes.
module occ_front import occ_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [151:0]  s_tdata,
	input  logic [1:0]    s_tuser,
	input  cfg_t          cfg,
	input  logic          q_full,
	output logic          q_push,
	output item_t         q_item,
	output logic          busy
);

	logic in_s, in_e;
	logic seen_q;

	always_comb begin
		q_item.func       = s_tuser;
		q_item.start_x    = s_tdata[31:0];
		q_item.start_y    = s_tdata[63:32];
		q_item.end_x      = s_tdata[95:64];
		q_item.end_y      = s_tdata[127:96];
		q_item.cell_addr  = s_tdata[143:128];
		q_item.cell_value = s_tdata[151:144];
		in_s = (q_item.start_x >= cfg.min_x) && (q_item.start_x < cfg.max_x) &&
		       (q_item.start_y >= cfg.min_y) && (q_item.start_y < cfg.max_y);
		in_e = (q_item.end_x >= cfg.min_x) && (q_item.end_x < cfg.max_x) &&
		       (q_item.end_y >= cfg.min_y) && (q_item.end_y < cfg.max_y);
		q_item.oob = !(in_s && in_e);
	end

	assign s_tready = !q_full;
	// drop the unused code here so the back end never sees it
	assign q_push   = s_tvalid && s_tready && (s_tuser != 2'd3);

	// registered activity flag: high the cycle after an accepted transfer; the top reads it on cfg writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else begin
			seen_q <= s_tvalid && s_tready;
		end
	end
	assign busy = seen_q;

endmodule

>>> sv/occ_queue.sv
// Short request queue between the front and back ends.
module occ_queue import occ_pkg::*; #(
	parameter int DEPTH = QDEPTH
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  item_t  push_item,
	input  logic   pop,
	output item_t  head,
	output logic   empty,
	output logic   full
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t          ent_q [DEPTH];
	logic [AW-1:0]  wp_q, rp_q;
	logic [CW-1:0]  cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CW'(DEPTH));
	assign head  = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> sv/occ_back.sv
// Back end: grid store, length root, shared divider, sample walk and result register.
module occ_back import occ_pkg::*; #(
	parameter int GRID_W    = GRID_W_DEF,
	parameter int GRID_H    = GRID_H_DEF,
	parameter int MAX_STEPS = MAX_STEPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  item_t       head,
	input  logic        empty,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata
);

	localparam int NW = $clog2(MAX_STEPS + 1);
	localparam logic [31:0] GW32 = 32'(GRID_W);
	localparam logic [31:0] GH32 = 32'(GRID_H);
	localparam logic [15:0] GW16 = 16'(GRID_W);
	localparam logic [NW-1:0] NMAX = NW'(MAX_STEPS);

	logic [7:0] mem [2**STORE_AW];

	bstate_t state_q, state_d;
	bdone_t  done_q;

	logic                point_q;
	logic signed [31:0]  sx_q, sy_q;
	logic                negx_q, negy_q;
	logic [31:0]         ux_q, uy_q;
	logic [63:0]         mul_q, sqa_q;
	logic [65:0]         rad_q;
	logic [35:0]         rem_q;
	logic [33:0]         root_q;
	logic [5:0]          cnt_q;
	logic [33:0]         dvd_q, dvs_q;
	logic [34:0]         drem_q;
	logic [NW-1:0]       n_q, i_q, rx_q, ry_q, rax_q, ray_q;
	logic [31:0]         qx_q, qy_q, accx_q, accy_q;
	logic signed [33:0]  px_q, py_q;
	logic                lowx_q, lowy_q, off_q;
	logic [31:0]         cellx_q;
	logic [7:0]          rd_q;
	logic                out_vld_q;
	logic [8:0]          out_pv_q, pv_q;
	logic [1:0]          out_ss_q, ss_q;

	// combinational helpers
	logic signed [32:0] hdx, hdy;
	logic [31:0]        hux, huy;
	logic [35:0]        rt_rem, rt_trial;
	logic               rt_take;
	logic [34:0]        dv_rem;
	logic               dv_take;
	logic [33:0]        minx_e, miny_e;
	logic [31:0]        dx_off, dy_off;
	logic [31:0]        celly;
	logic               off_now;
	logic [15:0]        raddr;
	logic [NW-1:0]      n_new;
	logic [NW:0]        sumx, sumy;
	logic               hit;
	logic               load_out, mem_we, mem_re, last_iter;

	always_comb begin
		hdx = 33'(head.end_x) - 33'(head.start_x);
		hdy = 33'(head.end_y) - 33'(head.start_y);
		hux = hdx[32] ? 32'(-hdx) : hdx[31:0];
		huy = hdy[32] ? 32'(-hdy) : hdy[31:0];

		rt_rem   = {rem_q[33:0], rad_q[65:64]};
		rt_trial = {root_q, 2'b01};
		rt_take  = rt_rem >= rt_trial;

		dv_rem  = {drem_q[33:0], dvd_q[33]};
		dv_take = dv_rem >= {1'b0, dvs_q};

		minx_e = {{2{cfg.min_x[31]}}, cfg.min_x};
		miny_e = {{2{cfg.min_y[31]}}, cfg.min_y};
		dx_off = 32'(px_q - $signed(minx_e));
		dy_off = 32'(py_q - $signed(miny_e));

		celly   = mul_q[63:32];
		off_now = lowx_q || lowy_q || (cellx_q >= GW32) || (celly >= GH32);
		raddr   = 16'(celly[15:0] * GW16) + cellx_q[15:0];

		if ((cfg.step_len == '0) || (dvd_q >= 34'(MAX_STEPS))) begin
			n_new = NMAX;
		end else if (dvd_q == '0) begin
			n_new = NW'(1);
		end else begin
			n_new = dvd_q[NW-1:0];
		end

		sumx = {1'b0, rax_q} + {1'b0, rx_q};
		sumy = {1'b0, ray_q} + {1'b0, ry_q};
		hit  = off_q || (rd_q != 8'd0);
		last_iter = (cnt_q == 6'(DIV_BITS - 1));
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (!empty && done_q == B_RUN) begin
					if (head.func == FN_POINT) begin
						state_d = B_MULX;
					end else if (head.func == FN_SEG && !head.oob) begin
						state_d = B_SQX;
					end
				end
			end
			B_SQX:   state_d = B_SQY;
			B_SQY:   state_d = B_SUM;
			B_SUM:   state_d = B_ROOT;
			B_ROOT:  state_d = (cnt_q == 6'(ROOT_ITERS - 1)) ? B_DIVN : B_ROOT;
			B_DIVN:  state_d = last_iter ? B_NSET : B_DIVN;
			B_NSET:  state_d = B_DIVX;
			B_DIVX:  state_d = last_iter ? B_LOADY : B_DIVX;
			B_LOADY: state_d = B_DIVY;
			B_DIVY:  state_d = last_iter ? B_WALK0 : B_DIVY;
			B_WALK0: state_d = B_SAMP;
			B_SAMP:  state_d = B_MULX;
			B_MULX:  state_d = B_MULY;
			B_MULY:  state_d = B_ADDR;
			B_ADDR:  state_d = B_CHK;
			B_CHK: begin
				if (point_q || hit || (i_q + 1'b1 == n_q)) begin
					state_d = B_IDLE;
				end else begin
					state_d = B_SAMP;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		pop    = (state_q == B_IDLE) && !empty && (done_q == B_RUN);
		mem_we = pop && (head.func == FN_WRITE);
		mem_re = (state_q == B_ADDR);
		load_out = (done_q == B_DONE) && (!out_vld_q || m_tready);
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[head.cell_addr] <= head.cell_value;
		end
		if (mem_re) begin
			rd_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			done_q    <= B_RUN;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				done_q    <= B_RUN;
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			if (pop && head.func == FN_SEG && head.oob) begin
				done_q <= B_DONE;
			end
			if (state_q == B_CHK && state_d == B_IDLE) begin
				done_q <= B_DONE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_pv_q <= pv_q;
			out_ss_q <= ss_q;
		end
		unique case (state_q)
			B_IDLE: begin
				if (pop) begin
					point_q <= (head.func == FN_POINT);
					sx_q    <= head.start_x;
					sy_q    <= head.start_y;
					negx_q  <= hdx[32];
					negy_q  <= hdy[32];
					ux_q    <= hux;
					uy_q    <= huy;
					px_q    <= 34'(head.start_x);
					py_q    <= 34'(head.start_y);
					pv_q    <= 9'd0;
					ss_q    <= ST_OUT;
				end
			end
			B_SQX: mul_q <= ux_q * ux_q;
			B_SQY: begin
				sqa_q <= mul_q;
				mul_q <= uy_q * uy_q;
			end
			B_SUM: begin
				rad_q  <= {1'b0, 65'(sqa_q) + 65'(mul_q)};
				rem_q  <= '0;
				root_q <= '0;
				cnt_q  <= '0;
			end
			B_ROOT: begin
				rad_q  <= {rad_q[63:0], 2'b00};
				rem_q  <= rt_take ? rt_rem - rt_trial : rt_rem;
				root_q <= {root_q[32:0], rt_take};
				cnt_q  <= cnt_q + 1'b1;
				if (cnt_q == 6'(ROOT_ITERS - 1)) begin
					dvd_q  <= {root_q[32:0], rt_take};
					dvs_q  <= {2'b00, cfg.step_len};
					drem_q <= '0;
					cnt_q  <= '0;
				end
			end
			B_DIVN, B_DIVX, B_DIVY: begin
				drem_q <= dv_take ? dv_rem - {1'b0, dvs_q} : dv_rem;
				dvd_q  <= {dvd_q[32:0], dv_take};
				cnt_q  <= cnt_q + 1'b1;
			end
			B_NSET: begin
				n_q    <= n_new;
				dvd_q  <= {2'b00, ux_q};
				dvs_q  <= 34'(n_new);
				drem_q <= '0;
				cnt_q  <= '0;
			end
			B_LOADY: begin
				qx_q   <= dvd_q[31:0];
				rx_q   <= drem_q[NW-1:0];
				dvd_q  <= {2'b00, uy_q};
				drem_q <= '0;
				cnt_q  <= '0;
			end
			B_WALK0: begin
				qy_q   <= dvd_q[31:0];
				ry_q   <= drem_q[NW-1:0];
				i_q    <= '0;
				accx_q <= '0;
				accy_q <= '0;
				rax_q  <= '0;
				ray_q  <= '0;
			end
			B_SAMP: begin
				px_q <= 34'(sx_q) + (negx_q ? -34'(accx_q) : 34'(accx_q));
				py_q <= 34'(sy_q) + (negy_q ? -34'(accy_q) : 34'(accy_q));
			end
			B_MULX: begin
				lowx_q <= px_q < $signed(minx_e);
				mul_q  <= dx_off * cfg.scale_x;
			end
			B_MULY: begin
				lowy_q  <= py_q < $signed(miny_e);
				cellx_q <= mul_q[63:32];
				mul_q   <= dy_off * cfg.scale_y;
			end
			B_ADDR: off_q <= off_now;
			B_CHK: begin
				if (point_q) begin
					pv_q <= off_q ? PV_OFF_GRID : {1'b0, rd_q};
					ss_q <= ST_FREE;
				end else begin
					pv_q <= 9'd0;
					ss_q <= hit ? ST_HIT : ST_FREE;
				end
				// carry the remainder into the quotient when it reaches n
				i_q <= i_q + 1'b1;
				if (sumx >= {1'b0, n_q}) begin
					rax_q  <= NW'(sumx - {1'b0, n_q});
					accx_q <= accx_q + qx_q + 32'd1;
				end else begin
					rax_q  <= sumx[NW-1:0];
					accx_q <= accx_q + qx_q;
				end
				if (sumy >= {1'b0, n_q}) begin
					ray_q  <= NW'(sumy - {1'b0, n_q});
					accy_q <= accy_q + qy_q + 32'd1;
				end else begin
					ray_q  <= sumy[NW-1:0];
					accy_q <= accy_q + qy_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {5'd0, out_ss_q, out_pv_q};

	a_samp_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_SAMP) |-> (i_q < n_q))
		else $error("sample index beyond segment count");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == B_IDLE) && (done_q == B_RUN))
		else $error("queue popped while busy");
	a_chk_after_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_CHK) |-> $past(state_q) == B_ADDR)
		else $error("cell check without a read");
	a_n_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_SAMP) |-> (n_q != '0))
		else $error("zero segment count");

endmodule

>>> sv/occupancy_grid_segment_check.sv
// Top level of the occupancy grid segment checker.
// A segment check with both endpoints in the box runs the squares, the length root and the
// shared divider (for the part count and both per-part offsets), then walks up to n samples
// (n up to MAX_STEPS), stopping at the first hit; a segment with an endpoint out of the box
// is answered with no walk. Each sample uses the one shared 32 x 32 multiplier (two
// products per sample) and the registered grid store read. A short queue lets requests be
// taken while the back end walks; one result register decouples the output. The grid store
// is not cleared: read only cells that were written.
module occupancy_grid_segment_check import occ_pkg::*; #(
	parameter int GRID_W    = GRID_W_DEF,
	parameter int GRID_H    = GRID_H_DEF,
	parameter int MAX_STEPS = MAX_STEPS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [151:0] s_tdata,   // start_x, start_y, end_x, end_y, cell_addr, cell_value
	input  logic [1:0]   s_tuser,   // func
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [15:0]  m_tdata,   // point_value[8:0], segment_status[10:9], zero fill
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_wdata
);

	cfg_t  cfg_q;
	item_t push_item, head;
	logic  push, pop, empty, full, fe_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_x    <= 32'sd0;
			cfg_q.min_y    <= 32'sd0;
			cfg_q.max_x    <= 32'sd16777216;
			cfg_q.max_y    <= 32'sd16777216;
			cfg_q.scale_x  <= 32'd65536;
			cfg_q.scale_y  <= 32'd65536;
			cfg_q.step_len <= 32'd65536;
		end else if (cfg_we && !fe_busy) begin
			unique case (cfg_index)
				REG_MIN_X:   cfg_q.min_x    <= cfg_wdata;
				REG_MIN_Y:   cfg_q.min_y    <= cfg_wdata;
				REG_MAX_X:   cfg_q.max_x    <= cfg_wdata;
				REG_MAX_Y:   cfg_q.max_y    <= cfg_wdata;
				REG_SCALE_X: cfg_q.scale_x  <= cfg_wdata;
				REG_SCALE_Y: cfg_q.scale_y  <= cfg_wdata;
				REG_STEP:    cfg_q.step_len <= cfg_wdata;
				default: ;
			endcase
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN_X:   cfg_q.min_x    <= cfg_wdata;
				REG_MIN_Y:   cfg_q.min_y    <= cfg_wdata;
				REG_MAX_X:   cfg_q.max_x    <= cfg_wdata;
				REG_MAX_Y:   cfg_q.max_y    <= cfg_wdata;
				REG_SCALE_X: cfg_q.scale_x  <= cfg_wdata;
				REG_SCALE_Y: cfg_q.scale_y  <= cfg_wdata;
				REG_STEP:    cfg_q.step_len <= cfg_wdata;
				default: ;
			endcase
		end
	end

	occ_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cfg      (cfg_q),
		.q_full   (full),
		.q_push   (push),
		.q_item   (push_item),
		.busy     (fe_busy)
	);

	occ_queue #(.DEPTH(QDEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.empty     (empty),
		.full      (full)
	);

	occ_back #(
		.GRID_W    (GRID_W),
		.GRID_H    (GRID_H),
		.MAX_STEPS (MAX_STEPS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for the occupancy grid segment checker.
module tb_top;
	import occ_pkg::*;

	localparam logic [1:0] FN_NONE  = 2'd3;
	localparam int         WD_LIMIT = 50000;
	localparam longint     ONE      = 65536;

	typedef struct {
		logic [1:0]  func;
		logic [31:0] sx, sy, ex, ey;
		logic [15:0] addr;
		logic [7:0]  val;
	} request_t;

	typedef struct {
		logic [8:0] pv;
		logic [1:0] st;
	} answer_t;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_tvalid = 0;
	logic         s_tready;
	logic [151:0] s_tdata = '0;
	logic [1:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 0;
	logic [15:0]  m_tdata;
	logic         cfg_we = 0;
	logic [2:0]   cfg_index = '0;
	logic [31:0]  cfg_wdata = '0;

	request_t    pend[$];
	answer_t     answers_due[$];
	logic [7:0]  grid_model [0:65535];
	// grid contents as they will stand once every queued request has gone in
	logic [7:0]  gen_val [0:65535];
	bit          gen_set [0:65535];
	int          fresh_q[$];
	longint      bx_lo, by_lo, bx_hi, by_hi;
	logic [63:0] sc_x, sc_y, step_q;
	int          errors = 0;
	int          gap = 0, stall = 0, hold = 0, wd = 0;
	bit          calm = 0, hold_req = 0;

	occupancy_grid_segment_check dut (.*);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	function automatic longint sx32(logic [31:0] v);
		return longint'(signed'(v));
	endfunction

	function automatic bit axis_cell(longint p, longint lo, logic [63:0] sc, longint lim,
		output longint c);
		logic [63:0] d;
		if (p < lo) return 0;
		d = (p - lo) & 64'hFFFF_FFFF;
		c = longint'((d * sc) >> 32);
		return c < lim;
	endfunction

	function automatic bit cell_index(longint x, longint y, output int idx);
		longint cx, cy;
		if (!axis_cell(x, bx_lo, sc_x, GRID_W_DEF, cx)) return 0;
		if (!axis_cell(y, by_lo, sc_y, GRID_H_DEF, cy)) return 0;
		idx = int'((cy * GRID_W_DEF + cx) & 16'hFFFF);
		return 1;
	endfunction

	function automatic bit cell_at(longint x, longint y, output logic [7:0] v);
		int idx;
		if (!cell_index(x, y, idx)) return 0;
		v = grid_model[idx];
		return 1;
	endfunction

	function automatic logic [63:0] root_floor(logic [65:0] v);
		logic [67:0] rem, trial, root;
		rem = 0;
		root = 0;
		for (int j = 32; j >= 0; j--) begin
			rem = (rem << 2) | v[2*j +: 2];
			trial = (root << 2) | 1;
			if (rem >= trial) begin
				rem -= trial;
				root = (root << 1) | 1;
			end else begin
				root = root << 1;
			end
		end
		return root[63:0];
	endfunction

	function automatic bit in_box(longint x, longint y);
		return x >= bx_lo && x < bx_hi && y >= by_lo && y < by_hi;
	endfunction

	// Number of parts a segment is cut into
	function automatic longint seg_parts(longint dx, longint dy);
		logic [63:0] ux, uy, seg_len;
		logic [65:0] sq;
		longint      n;
		ux = dx < 0 ? -dx : dx;
		uy = dy < 0 ? -dy : dy;
		sq = {2'b0, ux * ux} + {2'b0, uy * uy};
		seg_len = root_floor(sq);
		if (step_q == 0 || seg_len / step_q >= MAX_STEPS_DEF) n = MAX_STEPS_DEF;
		else n = longint'(seg_len / step_q);
		if (n == 0) n = 1;
		return n;
	endfunction

	function automatic logic [1:0] segment_verdict(longint sx, longint sy, longint ex, longint ey);
		longint     dx, dy, n;
		logic [7:0] v;
		if (!in_box(sx, sy) || !in_box(ex, ey)) return ST_OUT;
		dx = ex - sx;
		dy = ey - sy;
		n = seg_parts(dx, dy);
		for (longint i = 0; i < n; i++) begin
			if (!cell_at(sx + (i * dx) / n, sy + (i * dy) / n, v) || v != 0) return ST_HIT;
		end
		return ST_FREE;
	endfunction

	// Collect the never-written cells a request reads, in read order, up to the first obstacle
	function automatic void fresh_cells(request_t r);
		longint sx, sy, dx, dy, n;
		int     idx;
		sx = sx32(r.sx);
		sy = sx32(r.sy);
		dx = sx32(r.ex) - sx;
		dy = sx32(r.ey) - sy;
		fresh_q.delete();
		if (r.func == FN_POINT) begin
			if (cell_index(sx, sy, idx) && !gen_set[idx]) fresh_q.push_back(idx);
		end else if (r.func == FN_SEG && in_box(sx, sy) && in_box(sx + dx, sy + dy)) begin
			n = seg_parts(dx, dy);
			for (longint i = 0; i < n; i++) begin
				if (!cell_index(sx + (i * dx) / n, sy + (i * dy) / n, idx)) break;
				if (gen_set[idx]) begin
					if (gen_val[idx] != 0) break;
				end else if (fresh_q.size() == 0 || fresh_q[$] != idx) begin
					fresh_q.push_back(idx);
				end
			end
		end
	endfunction

	function automatic void enqueue(request_t r);
		if (r.func == FN_WRITE) begin
			gen_val[r.addr] = r.val;
			gen_set[r.addr] = 1;
		end
		pend.push_back(r);
	endfunction

	// Queue a request behind zero writes to the fresh cells it reads; refuse it when it
	// needs more than room of them. Gives the number of items queued.
	function automatic int offer(int room, logic [1:0] f, logic [31:0] sx, sy, ex, ey,
		logic [15:0] ad, logic [7:0] v);
		request_t r, w;
		r.func = f; r.sx = sx; r.sy = sy; r.ex = ex; r.ey = ey; r.addr = ad; r.val = v;
		fresh_cells(r);
		if (fresh_q.size() > room) return 0;
		w.func = FN_WRITE; w.sx = '0; w.sy = '0; w.ex = '0; w.ey = '0; w.val = 8'd0;
		foreach (fresh_q[j]) begin
			w.addr = 16'(fresh_q[j]);
			enqueue(w);
		end
		enqueue(r);
		return fresh_q.size() + 1;
	endfunction

	// Apply one accepted request to the grid copy and queue its answer
	function automatic void predict_answer(request_t r);
		answer_t    a;
		logic [7:0] v;
		a.pv = '0;
		a.st = ST_FREE;
		case (r.func)
			FN_WRITE: begin
				grid_model[r.addr] = r.val;
				return;
			end
			FN_POINT: a.pv = cell_at(sx32(r.sx), sx32(r.sy), v) ? {1'b0, v} : PV_OFF_GRID;
			FN_SEG:   a.st = segment_verdict(sx32(r.sx), sx32(r.sy), sx32(r.ex), sx32(r.ey));
			default:  return;
		endcase
		answers_due.push_back(a);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		request_t r;
		bit fire;
		if (!arst_n) begin
			s_tvalid <= 0;
		end else begin
			fire = s_tvalid && s_tready;
			if (fire) begin
				r.func = s_tuser;
				{r.val, r.addr, r.ey, r.ex, r.sy, r.sx} = s_tdata;
				predict_answer(r);
			end
			if (!s_tvalid || fire) begin
				if (gap > 0) begin
					gap--;
					s_tvalid <= 0;
				end else if (pend.size() > 0 && !calm && $urandom_range(0, 5) == 0) begin
					gap = $urandom_range(1, 4) - 1;
					s_tvalid <= 0;
				end else if (pend.size() > 0) begin
					r = pend.pop_front();
					s_tdata <= {r.val, r.addr, r.ey, r.ex, r.sy, r.sx};
					s_tuser <= r.func;
					s_tvalid <= 1;
				end else begin
					s_tvalid <= 0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		answer_t a;
		if (!arst_n) begin
			m_tready <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (answers_due.size() == 0) begin
					$error("unexpected answer %h", m_tdata);
					errors++;
				end else begin
					a = answers_due.pop_front();
					if (m_tdata[8:0] !== a.pv) begin
						$error("point_value expected %h got %h", a.pv, m_tdata[8:0]);
						errors++;
					end
					if (m_tdata[10:9] !== a.st) begin
						$error("segment_status expected %h got %h", a.st, m_tdata[10:9]);
						errors++;
					end
				end
			end
			if (hold_req) begin
				hold = 400;
				hold_req = 0;
			end
			if (hold > 0) begin
				hold--;
				m_tready <= 0;
			end else if (stall > 0) begin
				stall--;
				m_tready <= 0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				stall = $urandom_range(1, 4) - 1;
				m_tready <= 0;
			end else begin
				m_tready <= 1;
			end
		end
	end

	// Abort when requests are pending but nothing moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we ||
			(pend.size() == 0 && answers_due.size() == 0 && !s_tvalid)) begin
			wd = 0;
		end else if (++wd >= WD_LIMIT) begin
			$display("FAIL occupancy_grid_segment_check");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] v);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= v;
		case (idx)
			REG_MIN_X:   bx_lo = sx32(v);
			REG_MIN_Y:   by_lo = sx32(v);
			REG_MAX_X:   bx_hi = sx32(v);
			REG_MAX_Y:   by_hi = sx32(v);
			REG_SCALE_X: sc_x = v;
			REG_SCALE_Y: sc_y = v;
			default:     step_q = v;
		endcase
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic set_regs(logic [31:0] mnx, mny, mxx, mxy, scx, scy, stp);
		write_reg(REG_MIN_X, mnx);
		write_reg(REG_MIN_Y, mny);
		write_reg(REG_MAX_X, mxx);
		write_reg(REG_MAX_Y, mxy);
		write_reg(REG_SCALE_X, scx);
		write_reg(REG_SCALE_Y, scy);
		write_reg(REG_STEP, stp);
	endtask

	task automatic drain();
		while (pend.size() > 0 || s_tvalid || answers_due.size() > 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic push(logic [1:0] f, logic [31:0] sx, sy, ex, ey, logic [15:0] ad,
		logic [7:0] v);
		void'(offer(65536, f, sx, sy, ex, ey, ad, v));
	endtask

	function automatic logic [31:0] clamp32(longint v);
		if (v > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
		if (v < -64'sh8000_0000) return 32'h8000_0000;
		return v[31:0];
	endfunction

	// Mostly near or inside the box, sometimes anywhere; half the time a small hot corner
	function automatic logic [31:0] pick_coord(longint lo, longint hi);
		longint span;
		if (hi <= lo || $urandom_range(0, 9) == 0) return $urandom;
		span = hi - lo;
		if ($urandom_range(0, 1) == 0 && span > 16 * ONE) span = 16 * ONE;
		return clamp32(lo - span / 8 + longint'({$urandom, $urandom} % (span + span / 4 + 1)));
	endfunction

	task automatic random_batch(int count);
		logic [31:0] sx, sy, ex, ey;
		int k, left;
		left = count;
		while (left > 0) begin
			k = $urandom_range(0, 19);
			sx = pick_coord(bx_lo, bx_hi);
			sy = pick_coord(by_lo, by_hi);
			if ($urandom_range(0, 4) == 0) begin
				ex = pick_coord(bx_lo, bx_hi);
				ey = pick_coord(by_lo, by_hi);
			end else begin
				ex = clamp32(sx32(sx) + $signed($urandom_range(0, 16 * ONE)) - 8 * ONE);
				ey = clamp32(sx32(sy) + $signed($urandom_range(0, 16 * ONE)) - 8 * ONE);
			end
			if (k < 6)
				left -= offer(0, FN_WRITE, $urandom, $urandom, $urandom, $urandom,
					$urandom_range(0, 1) ? 16'($urandom) : {4'd0, 4'($urandom), 4'd0, 4'($urandom)},
					$urandom_range(0, 2) == 0 ? 8'($urandom) : 8'd0);
			else if (k < 11)
				left -= offer(1, FN_POINT, sx, sy, $urandom, $urandom, 16'($urandom),
					8'($urandom));
			else if (k < 19)
				left -= offer(4, FN_SEG, sx, sy, ex, ey, 16'($urandom), 8'($urandom));
			else
				left -= offer(0, FN_NONE, $urandom, $urandom, $urandom, $urandom,
					16'($urandom), 8'($urandom));
		end
	endtask

	initial begin
		bx_lo = 0; by_lo = 0; bx_hi = 256 * ONE; by_hi = 256 * ONE;
		sc_x = ONE; sc_y = ONE; step_q = ONE;
		for (int i = 0; i < 65536; i++) grid_model[i] = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		repeat (4) @(posedge clk);

		push(FN_WRITE, 0, 0, 0, 0, 20 * 256 + 10, 8'hFF);
		push(FN_POINT, 32'h000A_8000, 32'h0014_8000, 0, 0, 0, 0);
		push(FN_POINT, 0, 0, 0, 0, 0, 0);
		push(FN_POINT, 32'h00FF_FFFF, 32'h00FF_FFFF, 0, 0, 0, 0);
		push(FN_POINT, 32'hFFFF_0000, 32'h0001_0000, 0, 0, 0, 0);
		push(FN_POINT, 32'h0100_0000, 0, 0, 0, 0, 0);
		push(FN_POINT, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0);
		push(FN_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
		push(FN_SEG, 0, 32'h0014_8000, 32'h001E_0000, 32'h0014_8000, 0, 0);
		push(FN_SEG, 0, 0, 32'h000C_0000, 0, 0, 0);
		push(FN_SEG, 32'h0005_0000, 32'h0005_0000, 32'h0005_0000, 32'h0005_0000, 0, 0);
		// obstacle early on the long diagonal keeps the walk short
		push(FN_WRITE, 0, 0, 0, 0, 16'h0303, 8'h40);
		push(FN_SEG, 0, 0, 32'h00FF_0000, 32'h00FF_0000, 0, 0);
		push(FN_SEG, 0, 0, 32'h0100_0000, 0, 0, 0);
		push(FN_SEG, 32'h8000_0000, 0, 0, 0, 0, 0);
		push(FN_WRITE, 0, 0, 0, 0, 16'hFFFF, 8'h01);
		push(FN_POINT, 32'h00FF_8000, 32'h00FF_8000, 0, 0, 0, 0);
		push(FN_SEG, 32'h00F0_0000, 32'h00F0_0000, 32'h00FF_8000, 32'h00FF_8000, 0, 0);
		push(FN_WRITE, 0, 0, 0, 0, 16'hFFFF, 8'h00);
		push(FN_POINT, 32'h00FF_8000, 32'h00FF_8000, 0, 0, 0, 0);
		random_batch(80);
		drain();

		// negative lower bounds, fine scales, short step; long segments saturate
		set_regs(32'hFFF8_0000, 32'hFFFC_0000, 32'h0064_0000, 32'h003C_0000,
			32'h0002_0000, 32'h0002_8000, 32'h0000_2000);
		push(FN_WRITE, 0, 0, 0, 0, 16'h0000, 8'h5A);
		push(FN_SEG, 32'hFFF8_0000, 32'hFFFC_0000, 32'h0063_0000, 32'h003B_0000, 0, 0);
		random_batch(100);
		drain();

		// widest box with the smallest scale and the largest step
		set_regs(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF);
		random_batch(60);
		drain();

		// largest scale, smallest step: samples fall off the grid
		set_regs(0, 0, 32'h0040_0000, 32'h0040_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001);
		random_batch(40);
		drain();

		// empty box in x
		set_regs(32'h0005_0000, 0, 32'h0005_0000, 32'h0100_0000, 32'(ONE), 32'(ONE), 32'(ONE));
		random_batch(30);
		drain();

		set_regs(0, 0, 32'h0100_0000, 32'h0100_0000, 32'(ONE), 32'(ONE), 32'(ONE));
		hold_req = 1;
		random_batch(80);
		while (pend.size() > 0) @(posedge clk);
		calm = 1;
		random_batch(100);
		drain();

		if (errors == 0)
			$display("PASS occupancy_grid_segment_check");
		else
			$display("FAIL occupancy_grid_segment_check");
		$finish;
	end

endmodule

>>> filelist.f
sv/occ_pkg.sv
sv/occ_front.sv
sv/occ_queue.sv
sv/occ_back.sv
sv/occupancy_grid_segment_check.sv
verif/tb_top.sv
